FILE: rtl/bpcd_pkg.sv
// shared types and constants for the debounced button press counter
package bpcd_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned IDLE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // stream widths, rounded up to whole bytes
  localparam int unsigned IN_FIELDS_W  = CMD_W + 1 + COUNT_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = COUNT_W + TIME_W + 1;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;
  localparam logic [IDLE_W-1:0]     IDLE_RESET     = 16'd2000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 2'd0,
    CMD_CLEAR_COUNT = 2'd1,
    CMD_LOAD_COUNT  = 2'd2,
    CMD_CLEAR_DUR   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_IDLE_MS  = 2'd1,
    REG_IDLE_EN  = 2'd2,
    REG_NONE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [IDLE_W-1:0]     idle_reset_ms;
    logic                  idle_reset_enable;
  } cfg_t;

  typedef struct packed {
    cmd_t               command;
    logic               button_pressed;
    logic [COUNT_W-1:0] count_value;
  } tick_t;

  typedef struct packed {
    logic [COUNT_W-1:0] press_count;
    logic [TIME_W-1:0]  press_duration_ms;
    logic               button_held;
  } result_t;

endpackage

FILE: rtl/bpcd_cfg.sv
// configuration register file
module bpcd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpcd_pkg::CFG_DATA_W-1:0] cfg_data,
  output bpcd_pkg::cfg_t                cfg
);
  import bpcd_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms       <= DEBOUNCE_RESET;
      regs.idle_reset_ms     <= IDLE_RESET;
      regs.idle_reset_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE: regs.debounce_ms       <= cfg_data[DEBOUNCE_W-1:0];
        REG_IDLE_MS:  regs.idle_reset_ms     <= cfg_data[IDLE_W-1:0];
        REG_IDLE_EN:  regs.idle_reset_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: rtl/bpcd_tick.sv
// press state registers and the per-tick update logic
module bpcd_tick (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bpcd_pkg::tick_t   tick,
  input  bpcd_pkg::cfg_t    cfg,
  output bpcd_pkg::result_t result
);
  import bpcd_pkg::*;

  logic [TIME_W-1:0]  time_now;
  logic [TIME_W-1:0]  press_start;
  logic [TIME_W-1:0]  last_count;
  logic               armed;
  logic               held;
  logic [COUNT_W-1:0] count;
  // holds the last reported duration, which is also the stored duration
  logic [TIME_W-1:0]  duration;

  logic [TIME_W-1:0]  now;
  logic [TIME_W-1:0]  since_start;
  logic [TIME_W-1:0]  idle_gap;
  logic [TIME_W-1:0]  press_start_next;
  logic [TIME_W-1:0]  last_count_next;
  logic               armed_next;
  logic               held_next;
  logic [COUNT_W-1:0] count_next;
  logic [TIME_W-1:0]  duration_next;
  logic               down;

  always_comb begin
    down             = tick.button_pressed;
    now              = time_now + 32'd1;
    armed_next       = armed;
    held_next        = held;
    press_start_next = press_start;
    last_count_next  = last_count;
    count_next       = count;
    duration_next    = duration;

    if (down && !armed) begin
      armed_next       = 1'b1;
      press_start_next = now;
    end
    since_start = now - press_start_next;

    if (down && armed_next && !held && since_start > {24'd0, cfg.debounce_ms}) begin
      count_next      = count + 16'd1;
      armed_next      = 1'b0;
      held_next       = 1'b1;
      last_count_next = now;
    end

    if (held_next && down) begin
      duration_next = since_start;
    end

    if (!down && held_next) begin
      press_start_next = now;
      held_next        = 1'b0;
    end

    idle_gap = now - last_count_next;
    if (cfg.idle_reset_enable && idle_gap > {16'd0, cfg.idle_reset_ms}) begin
      count_next = '0;
    end

    unique case (tick.command)
      CMD_TICK:        ;
      CMD_CLEAR_COUNT: count_next    = '0;
      CMD_LOAD_COUNT:  count_next    = tick.count_value;
      CMD_CLEAR_DUR:   duration_next = '0;
      default: ;
    endcase

    // unchanged since the last report reads as zero
    if (duration_next == duration) begin
      duration_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      press_start <= '0;
      last_count  <= '0;
      armed       <= 1'b0;
      held        <= 1'b0;
      count       <= '0;
      duration    <= '0;
    end else if (step) begin
      time_now    <= now;
      press_start <= press_start_next;
      last_count  <= last_count_next;
      armed       <= armed_next;
      held        <= held_next;
      count       <= count_next;
      duration    <= duration_next;
    end
  end

  assign result.press_count       = count_next;
  assign result.press_duration_ms = duration_next;
  assign result.button_held       = held_next;

endmodule

FILE: rtl/button_press_counter_debounce_top.sv
// top level: input beat register, press logic, result register
//
//  channel  | dir | fields (lowest bit first)
//  s_axis   | in  | command[1:0], button_pressed[2], count_value[18:3]
//  m_axis   | out | press_count[15:0], press_duration_ms[47:16], button_held[48]
//  cfg      | in  | debounce_ms (0), idle_reset_ms (1), idle_reset_enable (2)
//
// one tick per clock sustained while m_axis does not stall; an accepted beat passes through the
// input register, then the update logic into the result register
// reset clears the time counter, press state, count and the last duration
// a stall on m_axis holds the result and stops the update; s_axis_tready
// drops in the same cycle once the input register holds a beat
module button_press_counter_debounce_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // command, button_pressed, count_value
  input  logic [bpcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // press_count, press_duration_ms, button_held
  output logic [bpcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [bpcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bpcd_pkg::*;

  cfg_t    cfg;
  tick_t   in_beat;
  logic    in_valid;
  result_t result;
  result_t out_beat;
  logic    out_valid;
  logic    advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_beat.command        <= cmd_t'(s_axis_tdata[CMD_W-1:0]);
      in_beat.button_pressed <= s_axis_tdata[CMD_W];
      in_beat.count_value    <= s_axis_tdata[CMD_W+1 +: COUNT_W];
    end
  end

  bpcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpcd_tick u_tick (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .tick   (in_beat),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                          out_beat.button_held,
                          out_beat.press_duration_ms,
                          out_beat.press_count};

endmodule

FILE: tb/button_press_counter_debounce_top_test.sv
// testbench for the debounced button press counter: directed script, random presses, scoreboard
`timescale 1ns / 100ps

module button_press_counter_debounce_top_test;
  import bpcd_pkg::*;

  typedef struct packed {
    bit                  wr;      // register write instead of a tick
    cfg_reg_t            regsel;
    logic [15:0]         value;   // register data, or the load value of a tick
    cmd_t                cmd;
    logic                btn;
    logic [7:0]          reps;
    bit                  typed;   // want holds the result for a single tick
    result_t             want;
  } script_row_t;

  localparam int unsigned SCRIPT_LEN = 20;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state and its copy of the registers
  logic [DEBOUNCE_W-1:0] debounce_cfg = DEBOUNCE_RESET;
  logic [IDLE_W-1:0]     idle_ms_cfg = IDLE_RESET;
  logic                  idle_en_cfg = 1'b0;
  logic [TIME_W-1:0]     clock_ms = '0;
  logic [TIME_W-1:0]     start_ms = '0;
  logic [TIME_W-1:0]     last_count_ms = '0;
  logic [TIME_W-1:0]     dur_ms = '0;
  logic [TIME_W-1:0]     reported_ms = '0;
  logic                  armed = 1'b0;
  logic                  held = 1'b0;
  logic [COUNT_W-1:0]    presses = '0;

  result_t     pending_results[$];
  int unsigned mismatch_count = 0;
  bit          quiet_run = 1'b0;
  script_row_t script [SCRIPT_LEN];

  button_press_counter_debounce_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (quiet_run) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one millisecond tick of the press logic
  task automatic advance_press_model(input cmd_t c, input logic down,
                                     input logic [COUNT_W-1:0] load, output result_t r);
    logic [TIME_W-1:0] now;
    clock_ms = clock_ms + 32'd1;
    now = clock_ms;
    if (down && !armed) begin
      armed = 1'b1;
      start_ms = now;
    end
    if (down && armed && !held && (now - start_ms) > 32'(debounce_cfg)) begin
      presses = presses + 16'd1;
      armed = 1'b0;
      held = 1'b1;
      last_count_ms = now;
    end
    if (held && down) dur_ms = now - start_ms;
    if (!down && held) begin
      start_ms = now;
      held = 1'b0;
    end
    if (idle_en_cfg && (now - last_count_ms) > 32'(idle_ms_cfg)) presses = '0;
    case (c)
      CMD_CLEAR_COUNT: presses = '0;
      CMD_LOAD_COUNT:  presses = load;
      CMD_CLEAR_DUR:   dur_ms = '0;
      default: ;
    endcase
    // an unchanged duration reads as zero
    if (dur_ms == reported_ms) dur_ms = '0;
    reported_ms = dur_ms;
    r.press_count = presses;
    r.press_duration_ms = dur_ms;
    r.button_held = held;
  endtask

  task automatic send_tick(input cmd_t c, input logic b, input logic [COUNT_W-1:0] v,
                           input bit typed, input result_t want);
    logic [IN_DATA_W-1:0] beat;
    result_t r;
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat = '0;
    beat[IN_FIELDS_W-1:0] = {v, b, c};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= beat;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_press_model(c, b, v, r);
    pending_results.push_back(typed ? want : r);
  endtask

  // hold the sender until every result is back or the wait limit runs out
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE: debounce_cfg = val[DEBOUNCE_W-1:0];
      REG_IDLE_MS:  idle_ms_cfg = val[IDLE_W-1:0];
      REG_IDLE_EN:  idle_en_cfg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // presses held past the debounce time, short bounces, long idle stretches and some noise
  task automatic run_presses(input int unsigned beats);
    int unsigned done;
    int unsigned down_len;
    int unsigned up_len;
    int unsigned k;
    int unsigned burst;
    logic lvl;
    cmd_t c;
    done = 0;
    while (done < beats) begin
      if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 4);
        for (k = 0; k < burst && done < beats; k++) begin
          send_tick(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    16'($urandom), 1'b0, '0);
          done++;
        end
      end else begin
        if ($urandom_range(0, 9) < 7) down_len = debounce_cfg + $urandom_range(2, 6);
        else down_len = $urandom_range(1, debounce_cfg + 1);
        up_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
        for (k = 0; k < down_len + up_len && done < beats; k++) begin
          lvl = (k < down_len);
          if ($urandom_range(0, 29) == 0) lvl = !lvl;  // contact bounce
          c = ($urandom_range(0, 6) == 0) ? cmd_t'($urandom_range(1, 3)) : CMD_TICK;
          send_tick(c, lvl, 16'($urandom), 1'b0, '0);
          done++;
        end
      end
    end
  endtask

  // result side: random stalls, scoreboard compare
  initial begin
    int unsigned stall_left;
    result_t got;
    result_t want;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.press_count = m_axis_tdata[COUNT_W-1:0];
        got.press_duration_ms = m_axis_tdata[COUNT_W+TIME_W-1:COUNT_W];
        got.button_held = m_axis_tdata[COUNT_W+TIME_W];
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: count %h duration %0d held %b",
                     got.press_count, got.press_duration_ms, got.button_held);
        end else begin
          want = pending_results.pop_front();
          if (got.press_count !== want.press_count ||
              got.press_duration_ms !== want.press_duration_ms ||
              got.button_held !== want.button_held) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch (exp/got): count %h/%h duration %0d/%0d held %b/%b",
                       want.press_count, got.press_count, want.press_duration_ms,
                       got.press_duration_ms, want.button_held, got.button_held);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned p;
    int unsigned beats;
    logic [DEBOUNCE_W-1:0] deb;
    logic [IDLE_W-1:0] idl;
    logic en;

    // first two ticks run on the reset register values
    script[0]  = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b0, 8'd1, 1, '{16'h0000, 32'd0, 1'b0}};
    script[1]  = '{0, REG_NONE, 16'hFFFF, CMD_LOAD_COUNT, 1'b0, 8'd1, 1,
                   '{16'hFFFF, 32'd0, 1'b0}};
    script[2]  = '{1, REG_DEBOUNCE, 16'd1, CMD_TICK, 1'b0, 8'd0, 0, '0};
    script[3]  = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b1, 8'd2, 0, '0};
    // this press counts and the count wraps to zero
    script[4]  = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b1, 8'd1, 0, '0};
    // still down: re-arms with a new start time
    script[5]  = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b1, 8'd2, 0, '0};
    script[6]  = '{0, REG_NONE, 16'h0000, CMD_CLEAR_DUR, 1'b1, 8'd1, 0, '0};
    script[7]  = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b1, 8'd1, 0, '0};
    script[8]  = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b0, 8'd1, 0, '0};
    // released during debounce, stays armed with the old start
    script[9]  = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b1, 8'd1, 0, '0};
    script[10] = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b0, 8'd2, 0, '0};
    script[11] = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b1, 8'd1, 0, '0};
    script[12] = '{0, REG_NONE, 16'h0000, CMD_CLEAR_COUNT, 1'b0, 8'd1, 1,
                   '{16'h0000, 32'd0, 1'b0}};
    script[13] = '{0, REG_NONE, 16'h0000, CMD_LOAD_COUNT, 1'b1, 8'd1, 0, '0};
    script[14] = '{1, REG_IDLE_MS, 16'd0, CMD_TICK, 1'b0, 8'd0, 0, '0};
    script[15] = '{1, REG_IDLE_EN, 16'd1, CMD_TICK, 1'b0, 8'd0, 0, '0};
    script[16] = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b0, 8'd1, 0, '0};
    // load lands after the idle clear
    script[17] = '{0, REG_NONE, 16'h00FF, CMD_LOAD_COUNT, 1'b0, 8'd1, 1,
                   '{16'h00FF, 32'd0, 1'b0}};
    script[18] = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b1, 8'd3, 0, '0};
    script[19] = '{0, REG_NONE, 16'h0000, CMD_TICK, 1'b0, 8'd1, 0, '0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].wr) begin
        drain_results();
        set_reg(script[i].regsel, script[i].value);
      end else begin
        for (n = 0; n < script[i].reps; n++)
          send_tick(script[i].cmd, script[i].btn, script[i].value,
                    script[i].typed, script[i].want);
      end
    end

    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin deb = 8'd0;   idl = 16'd0;     en = 1'b1; beats = 70;  end
        1: begin deb = 8'd255; idl = 16'hFFFF;  en = 1'b1; beats = 280; end
        2: begin deb = DEBOUNCE_RESET; idl = IDLE_RESET; en = 1'b0; beats = 50; end
        3: begin deb = 8'd3;   idl = 16'd40;    en = 1'b1; beats = 60;  end
        default: begin
          deb = 8'($urandom_range(0, 12));
          idl = 16'($urandom_range(1, 120));
          en = 1'b1;
          beats = 70;
        end
      endcase
      drain_results();
      set_reg(REG_DEBOUNCE, 16'(deb));
      set_reg(REG_IDLE_MS, idl);
      set_reg(REG_IDLE_EN, 16'(en));
      quiet_run = ($urandom_range(0, 3) == 0);
      run_presses(beats);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
